>>> rtl/rotated_two_plane_pixel_plotter_core_macros.svh
// Assertion macros for the pixel plotter core.
`ifndef ROTATED_TWO_PLANE_PIXEL_PLOTTER_CORE_MACROS_SVH
`define ROTATED_TWO_PLANE_PIXEL_PLOTTER_CORE_MACROS_SVH
`ifndef SYNTH
`define RTPP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RTPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RTPP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RTPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rtpp_pkg.sv
`default_nettype none
package rtpp_pkg;
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 256;
   localparam int STORE_DEPTH  = 8192;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int BYTE_W       = 8;
   localparam int COORD_W      = 16;
   localparam int COLOR_W      = 3;
   localparam int ROT_W        = 2;
   localparam int PANEL_MAX    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
   localparam int PIX_W        = $clog2(PANEL_MAX);
   localparam int ROW_BYTES    = PANEL_WIDTH / 8;
   localparam int PLANE_BYTES  = PANEL_WIDTH * PANEL_HEIGHT / 8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 3'd0;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd1;
   localparam logic [COLOR_W-1:0] COLOR_RED   = 3'd2;

   localparam logic [ROT_W-1:0] ROT_MIRROR_XY    = 2'd0;
   localparam logic [ROT_W-1:0] ROT_SWAP_MIRROR_Y = 2'd1;
   localparam logic [ROT_W-1:0] ROT_IDENTITY     = 2'd2;
   localparam logic [ROT_W-1:0] ROT_SWAP_MIRROR_X = 2'd3;
   localparam logic [ROT_W-1:0] ROT_RESET        = ROT_SWAP_MIRROR_Y;

   typedef struct packed {
      logic                       opcode;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic [COLOR_W-1:0]         color;
      logic [STORE_AW-1:0]        byte_address;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              pixel_written;
   } rsp_type;

   typedef struct packed {
      logic [STORE_AW-1:0] idx;
      logic [BYTE_W-1:0]   mask;
      logic                set_bit;
      logic                wr_en;
   } xform_type;
endpackage
`default_nettype wire

>>> rtl/rtpp_xform.sv
`default_nettype none
module rtpp_xform (
   input  wire rtpp_pkg::req_type            req,
   input  wire logic [rtpp_pkg::ROT_W-1:0]   rotation,
   output rtpp_pkg::xform_type               xf
);
   localparam logic [rtpp_pkg::COORD_W-1:0] W_C = rtpp_pkg::COORD_W'(rtpp_pkg::PANEL_WIDTH);
   localparam logic [rtpp_pkg::COORD_W-1:0] H_C = rtpp_pkg::COORD_W'(rtpp_pkg::PANEL_HEIGHT);
   localparam logic [rtpp_pkg::PIX_W-1:0] W_MAX =
      rtpp_pkg::PIX_W'(rtpp_pkg::PANEL_WIDTH - 1);
   localparam logic [rtpp_pkg::PIX_W-1:0] H_MAX =
      rtpp_pkg::PIX_W'(rtpp_pkg::PANEL_HEIGHT - 1);
   localparam logic [rtpp_pkg::STORE_AW-1:0] ROW_C =
      rtpp_pkg::STORE_AW'(rtpp_pkg::ROW_BYTES);
   localparam logic [rtpp_pkg::STORE_AW-1:0] PLANE_C =
      rtpp_pkg::STORE_AW'(rtpp_pkg::PLANE_BYTES);

   logic [rtpp_pkg::COORD_W-1:0]  x_u, y_u, lw, lh;
   logic [rtpp_pkg::PIX_W-1:0]    xs, ys, px, py;
   logic                          outside;
   logic [rtpp_pkg::STORE_AW-1:0] row_base, col_off, plane_off;

   assign x_u = rtpp_pkg::COORD_W'(req.x_coord);
   assign y_u = rtpp_pkg::COORD_W'(req.y_coord);
   assign xs  = x_u[rtpp_pkg::PIX_W-1:0];
   assign ys  = y_u[rtpp_pkg::PIX_W-1:0];
   assign lw  = rotation[0] ? H_C : W_C;
   assign lh  = rotation[0] ? W_C : H_C;
   assign outside = x_u[rtpp_pkg::COORD_W-1] || y_u[rtpp_pkg::COORD_W-1] ||
                    (x_u >= lw) || (y_u >= lh);

   always_comb begin
      unique case (rotation)
         rtpp_pkg::ROT_MIRROR_XY: begin
            px = W_MAX - xs;
            py = H_MAX - ys;
         end
         rtpp_pkg::ROT_SWAP_MIRROR_Y: begin
            px = ys;
            py = H_MAX - xs;
         end
         rtpp_pkg::ROT_SWAP_MIRROR_X: begin
            px = W_MAX - ys;
            py = xs;
         end
         default: begin
            px = xs;
            py = ys;
         end
      endcase
   end

   assign row_base  = ROW_C * rtpp_pkg::STORE_AW'(py);
   assign col_off   = rtpp_pkg::STORE_AW'(px >> 3);
   assign plane_off = (req.color == rtpp_pkg::COLOR_RED) ? PLANE_C : '0;

   assign xf.idx     = row_base + col_off + plane_off;
   assign xf.mask    = rtpp_pkg::BYTE_W'(8'h80) >> px[2:0];
   assign xf.set_bit = (req.color == rtpp_pkg::COLOR_WHITE);
   assign xf.wr_en   = !outside && (req.color <= rtpp_pkg::COLOR_RED);
endmodule
`default_nettype wire

>>> rtl/rotated_two_plane_pixel_plotter_core.sv
// Channel   Handshake              Payload
// req       start / busy           req_data  (rtpp_pkg::req_type)
// rsp       rsp_valid strobe       rsp_data  (rtpp_pkg::rsp_type)
// csr       csr_valid / csr_ready  csr_wdata (rotation)
//
// Each item goes through accept, frame store read, then modify and write back;
// the result strobes in the cycle after write back, when the next item may be accepted.
// The frame store has one write port and a registered read port.
// After reset the store is cleared, one byte a cycle, all 8192 bytes, with busy high.
// The rotation register is always ready; the receiver cannot stall results.
`default_nettype none
`include "rotated_two_plane_pixel_plotter_core_macros.svh"
module rotated_two_plane_pixel_plotter_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire rtpp_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   output rtpp_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rtpp_pkg::ROT_W-1:0]      csr_wdata
);
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [rtpp_pkg::ROT_W-1:0]     rot_ff;
   logic [rtpp_pkg::STORE_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [rtpp_pkg::STORE_AW-1:0]  idx_ff, idx_in;
   logic [rtpp_pkg::BYTE_W-1:0]    mask_ff, mask_in;
   logic                           set_ff, set_in;
   logic                           wr_en_ff, wr_en_in;
   logic                           rd_op_ff, rd_op_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rtpp_pkg::rsp_type              rsp_ff, rsp_in;
   logic [rtpp_pkg::BYTE_W-1:0]    rd_q_ff;
   logic [rtpp_pkg::BYTE_W-1:0]    new_byte;
   logic                           mem_we;
   logic [rtpp_pkg::STORE_AW-1:0]  mem_wa;
   logic [rtpp_pkg::BYTE_W-1:0]    mem_wd;
   logic                           accept;
   rtpp_pkg::xform_type            xf;

   logic [rtpp_pkg::BYTE_W-1:0] frame_mem [rtpp_pkg::STORE_DEPTH];

   rtpp_xform u_xform (
      .req      (req_data),
      .rotation (rot_ff),
      .xf       (xf)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign new_byte = set_ff ? (rd_q_ff | mask_ff) : (rd_q_ff & ~mask_ff);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      set_in       = set_ff;
      wr_en_in     = wr_en_ff;
      rd_op_in     = rd_op_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = new_byte;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_op_in = (req_data.opcode == rtpp_pkg::OP_READ);
               idx_in   = (req_data.opcode == rtpp_pkg::OP_READ) ?
                          req_data.byte_address : xf.idx;
               mask_in  = xf.mask;
               set_in   = xf.set_bit;
               wr_en_in = (req_data.opcode == rtpp_pkg::OP_WRITE) && xf.wr_en;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we                = wr_en_ff;
            rsp_valid_in          = 1'b1;
            rsp_in.read_byte      = rd_op_ff ? rd_q_ff : '0;
            rsp_in.pixel_written  = wr_en_ff && (new_byte != rd_q_ff);
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rot_ff       <= rtpp_pkg::ROT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            rot_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      mask_ff  <= mask_in;
      set_ff   <= set_in;
      wr_en_ff <= wr_en_in;
      rd_op_ff <= rd_op_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= frame_mem[idx_ff];
   end

   `RTPP_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `RTPP_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_READ)
   `RTPP_ASSERT_NEXT(a_write_strobes, clock, reset, state_ff == ST_WRITE, rsp_valid)
   `RTPP_ASSERT_IMPL(a_clear_silent, clock, reset, state_ff == ST_CLEAR, !rsp_valid)
endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rtpp_pkg::*;

   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 305;
   localparam int DIRECTED_ROWS  = 24;
   localparam int MAX_REPORTS    = 10;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 4;

   typedef struct {
      logic opcode;
      int   x;
      int   y;
      int   color;
      int   addr;
      bit   typed;
      int   rb;
      bit   pw;
   } directed_row;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ROT_W-1:0]     csr_wdata = '0;

   logic [BYTE_W-1:0]    frame_image [STORE_DEPTH];
   logic [ROT_W-1:0]     rotation_shadow = ROT_RESET;
   int unsigned          recent_idx = 0;
   rsp_type              due_rsp [$];
   int                   mismatches = 0;
   int                   cycle_count = 0;
   int                   sender_idle_pct = 0;

   logic [ROT_W-1:0] phase_rotation [PHASES] = '{ROT_SWAP_MIRROR_X, ROT_MIRROR_XY, ROT_IDENTITY,
                                                 ROT_SWAP_MIRROR_Y, ROT_MIRROR_XY,
                                                 ROT_SWAP_MIRROR_X};
   int phase_idle [PHASES] = '{31, 31, 71, 71, 0, 0};

   // reset rotation: logical x spans the panel height, y the panel width
   directed_row directed_rows [DIRECTED_ROWS] = '{
      '{OP_READ,       0,      0, COLOR_WHITE,    0, 1'b1, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE, 8191, 1'b1, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE, 4096, 1'b1, 0, 1'b0},
      '{OP_WRITE, -32768, -32768, COLOR_WHITE,    0, 1'b1, 0, 1'b0},
      '{OP_WRITE,  32767,  32767, COLOR_BLACK,    0, 1'b1, 0, 1'b0},
      '{OP_WRITE,    256,      0, COLOR_WHITE,    0, 1'b1, 0, 1'b0},
      '{OP_WRITE,      0,    128, COLOR_WHITE,    0, 1'b1, 0, 1'b0},
      '{OP_WRITE,     -1,      5, COLOR_WHITE,    0, 1'b1, 0, 1'b0},
      '{OP_WRITE,      3,     -1, COLOR_RED,      0, 1'b1, 0, 1'b0},
      '{OP_WRITE,      0,      0, 7,              0, 1'b1, 0, 1'b0},
      '{OP_WRITE,      0,      0, 3,              0, 1'b1, 0, 1'b0},
      '{OP_WRITE,      0,      0, COLOR_WHITE,    0, 1'b0, 0, 1'b0},
      '{OP_WRITE,      0,      0, COLOR_WHITE,    0, 1'b0, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE, 4080, 1'b0, 0, 1'b0},
      '{OP_WRITE,    255,    127, COLOR_WHITE,    0, 1'b0, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE,   15, 1'b0, 0, 1'b0},
      '{OP_WRITE,      0,      0, COLOR_BLACK,    0, 1'b0, 0, 1'b0},
      '{OP_WRITE,      0,      0, COLOR_RED,      0, 1'b0, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE, 8176, 1'b0, 0, 1'b0},
      '{OP_READ,       0,      0, COLOR_WHITE, 4080, 1'b0, 0, 1'b0},
      '{OP_WRITE,    128,     64, COLOR_WHITE,    0, 1'b0, 0, 1'b0},
      '{OP_WRITE,    255,      0, COLOR_WHITE,    0, 1'b0, 0, 1'b0},
      '{OP_WRITE,      0,    127, COLOR_WHITE, 8191, 1'b0, 0, 1'b0},
      '{OP_READ,      -1,     -1, 7,           4095, 1'b0, 0, 1'b0}
   };

   rotated_two_plane_pixel_plotter_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit axes_swapped(input logic [ROT_W-1:0] rot);
      return rot == ROT_SWAP_MIRROR_Y || rot == ROT_SWAP_MIRROR_X;
   endfunction

   function automatic rsp_type plot_outcome(input req_type item);
      rsp_type           res;
      int                x;
      int                y;
      int                lw;
      int                lh;
      int                px;
      int                py;
      int unsigned       idx;
      logic [BYTE_W-1:0] bitmask;
      logic [BYTE_W-1:0] prior;
      logic [BYTE_W-1:0] upd;
      res = '0;
      if (item.opcode == OP_READ) begin
         res.read_byte = frame_image[item.byte_address];
         return res;
      end
      x  = int'(item.x_coord);
      y  = int'(item.y_coord);
      lw = axes_swapped(rotation_shadow) ? PANEL_HEIGHT : PANEL_WIDTH;
      lh = axes_swapped(rotation_shadow) ? PANEL_WIDTH : PANEL_HEIGHT;
      if (x < 0 || y < 0 || x >= lw || y >= lh || item.color > COLOR_RED)
         return res;
      case (rotation_shadow)
         ROT_MIRROR_XY: begin
            px = PANEL_WIDTH - x - 1;
            py = PANEL_HEIGHT - y - 1;
         end
         ROT_SWAP_MIRROR_Y: begin
            px = y;
            py = PANEL_HEIGHT - x - 1;
         end
         ROT_SWAP_MIRROR_X: begin
            px = PANEL_WIDTH - y - 1;
            py = x;
         end
         default: begin
            px = x;
            py = y;
         end
      endcase
      idx = ROW_BYTES * py + px / 8;
      if (item.color == COLOR_RED)
         idx += PLANE_BYTES;
      idx = idx % STORE_DEPTH;
      bitmask = 8'h80 >> (px % 8);
      prior = frame_image[STORE_AW'(idx)];
      upd = (item.color == COLOR_WHITE) ? (prior | bitmask) : (prior & ~bitmask);
      frame_image[STORE_AW'(idx)] = upd;
      recent_idx = idx;
      res.pixel_written = (upd != prior);
      return res;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      roll;
      int      lw;
      int      lh;
      int      xv;
      int      yv;
      item.opcode       = OP_WRITE;
      item.x_coord      = COORD_W'($urandom);
      item.y_coord      = COORD_W'($urandom);
      item.color        = COLOR_W'($urandom_range(7));
      item.byte_address = STORE_AW'($urandom);
      lw   = axes_swapped(rotation_shadow) ? PANEL_HEIGHT : PANEL_WIDTH;
      lh   = axes_swapped(rotation_shadow) ? PANEL_WIDTH : PANEL_HEIGHT;
      roll = $urandom_range(99);
      // put each coordinate near its upper end half the time, so writes cluster near one corner and bits get hit again
      xv = $urandom_range(1) ? $urandom_range(lw - 1) : lw - 1 - $urandom_range(7);
      yv = $urandom_range(1) ? $urandom_range(lh - 1) : lh - 1 - $urandom_range(7);
      if (roll < 50) begin
         item.x_coord = COORD_W'(xv);
         item.y_coord = COORD_W'(yv);
         item.color   = (roll < 42) ? COLOR_W'($urandom_range(1)) : COLOR_RED;
      end else if (roll < 75) begin
         item.opcode = OP_READ;
         if ($urandom_range(2) != 0)
            item.byte_address = STORE_AW'(recent_idx);
      end else if (roll < 83) begin
         xv = $urandom_range(1) ? lw + $urandom_range(3) : -1 - $urandom_range(3);
         item.x_coord = COORD_W'($urandom_range(1) ? xv : yv);
         item.y_coord = COORD_W'($urandom_range(1) ? lh + $urandom_range(3) : yv);
         if (item.x_coord == COORD_W'(yv) && item.y_coord == COORD_W'(yv))
            item.y_coord = COORD_W'(-1);
         item.color = COLOR_W'($urandom_range(2));
      end else if (roll < 90) begin
         item.color = COLOR_W'($urandom_range(2));
      end else begin
         item.x_coord = COORD_W'(xv);
         item.y_coord = COORD_W'(yv);
         item.color   = COLOR_W'($urandom_range(7, 3));
      end
      return item;
   endfunction

   task automatic send_req(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type model_rsp;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      model_rsp = plot_outcome(item);
      due_rsp.push_back(typed ? typed_rsp : model_rsp);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (due_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rotation(input logic [ROT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rotation_shadow = value;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_rsp.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected result: read_byte %02h pixel_written %0d",
                        rsp_data.read_byte, rsp_data.pixel_written);
            mismatches++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.read_byte !== want.read_byte ||
                rsp_data.pixel_written !== want.pixel_written) begin
               if (mismatches < MAX_REPORTS)
                  $display("mismatch: read_byte exp %02h got %02h, pixel_written exp %0d got %0d",
                           want.read_byte, rsp_data.read_byte,
                           want.pixel_written, rsp_data.pixel_written);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      req_type item;
      rsp_type want;
      foreach (frame_image[i])
         frame_image[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 31;
      foreach (directed_rows[r]) begin
         item.opcode         = directed_rows[r].opcode;
         item.x_coord        = COORD_W'(directed_rows[r].x);
         item.y_coord        = COORD_W'(directed_rows[r].y);
         item.color          = COLOR_W'(directed_rows[r].color);
         item.byte_address   = STORE_AW'(directed_rows[r].addr);
         want.read_byte      = BYTE_W'(directed_rows[r].rb);
         want.pixel_written  = directed_rows[r].pw;
         send_req(item, directed_rows[r].typed, want);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_rotation(phase_rotation[p]);
         sender_idle_pct = phase_idle[p];
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_req(random_item(), 1'b0, '0);
      end

      drain();
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
